// File: rtl/masked_rank_filter_unit_defines.svh
// ---------------------------------------------------------------------------
// masked rank filter assertion macros
// same-cycle and next-cycle implication checks on the block clock
// ---------------------------------------------------------------------------
`ifndef MASKED_RANK_FILTER_UNIT_DEFINES_SVH
`define MASKED_RANK_FILTER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define MRF_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MRF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mrf_pkg.sv
// ---------------------------------------------------------------------------
// mrf_pkg
// constants and helper functions of the masked rank filter
// ---------------------------------------------------------------------------
package mrf_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int WINDOW_SIZE = 5;
    localparam int HALF        = WINDOW_SIZE / 2;
    localparam int RING_ROWS   = 2 * WINDOW_SIZE;
    localparam int TAPS        = WINDOW_SIZE * WINDOW_SIZE;
    localparam int MEDIAN_DIV  = 2;

    localparam int PIX_W   = 8;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = 11;
    localparam int SLOT_W  = $clog2(RING_ROWS);
    localparam int DX_W    = $clog2(WINDOW_SIZE);
    localparam int CNT_W   = $clog2(TAPS + 1);
    localparam int ADDR_W  = 5;

    // reciprocal of ten in 16 fraction bits, exact for values below 16384
    localparam int MOD_RECIP = 6554;

    // register indexes
    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_MASK   = 3'd2;
    localparam logic [2:0] REG_RANK   = 3'd3;
    localparam logic [2:0] REG_MEDIAN = 3'd4;

    // input kinds
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // value modulo the ring depth
    function automatic logic [SLOT_W-1:0] mod_ring(input logic [11:0] x);
        logic [27:0] prod;
        logic [11:0] quo;
        logic [11:0] rem;
        prod = 28'(x) * 28'(MOD_RECIP);
        quo  = prod[27:16];
        rem  = x - 12'(quo * 12'(RING_ROWS));
        return rem[SLOT_W-1:0];
    endfunction

    // replicated-border column for window column dx
    function automatic logic [COL_W-1:0] col_pick(input logic [COL_W-1:0] c,
                                                   input logic [DX_W-1:0] dx,
                                                   input logic [COL_W-1:0] wm1);
        logic [11:0] t;
        t = 12'(c) + 12'(dx);
        if (t < 12'(HALF)) t = 12'd0;
        else t = t - 12'(HALF);
        if (t > 12'(wm1)) t = 12'(wm1);
        return t[COL_W-1:0];
    endfunction

    // ring slot of window row dy, clamped into the image
    function automatic logic [SLOT_W-1:0] row_slot(input logic [ROW_W-1:0] r,
                                                    input logic [DX_W-1:0] dy,
                                                    input logic [ROW_W-1:0] hm1,
                                                    input logic [SLOT_W-1:0] base);
        logic [11:0] t;
        t = 12'(r) + 12'(dy);
        if (t < 12'(HALF)) t = 12'd0;
        else t = t - 12'(HALF);
        if (t > 12'(hm1)) t = 12'(hm1);
        return mod_ring(12'(base) + t);
    endfunction

endpackage

// File: rtl/masked_rank_filter_unit.sv
// ---------------------------------------------------------------------------
// masked_rank_filter_unit
// streaming masked rank-order filter over a 5x5 replicated-border window
// ---------------------------------------------------------------------------
//  channel | dir | beat contents
//  s_*     | in  | tdata = pixel_in[7:0], tuser = func
//  m_*     | out | tdata = pixel_out[7:0], tuser = config_error, tlast = frame_last
//  apb     | in  | registers width, height, mask, rank, median at 0x00..0x10
//
//  an input beat is taken every cycle while the output queue has room and no
//  refresh runs; a beat whose output starts a row, or is the first after a
//  register write, refreshes: its five window columns come through the one
//  read port of the line banks, one column a cycle while the queue has room
//  reset is synchronous active low; the line banks are not cleared
//  a 2-entry output queue keeps input beats flowing while a result waits
// ---------------------------------------------------------------------------
`include "masked_rank_filter_unit_defines.svh"

module masked_rank_filter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_in
    input  logic        s_tuser,   // [0] func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] pixel_out
    output logic        m_tuser,   // [0] config_error
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [mrf_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mrf_pkg::*;

    // configuration registers
    logic [10:0] width_reg, height_reg;
    logic [24:0] mask_reg;
    logic [4:0]  rank_reg;
    logic        median_reg;
    logic        cfg_we;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd1024;
            height_reg <= 11'd1024;
            mask_reg   <= '1;
            rank_reg   <= 5'd12;
            median_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_WIDTH:  width_reg  <= pwdata[10:0];
                REG_HEIGHT: height_reg <= pwdata[10:0];
                REG_MASK:   mask_reg   <= pwdata[24:0];
                REG_RANK:   rank_reg   <= pwdata[4:0];
                REG_MEDIAN: median_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_MASK:   prdata = 32'(mask_reg);
            REG_RANK:   prdata = 32'(rank_reg);
            REG_MEDIAN: prdata = 32'(median_reg);
            default:    prdata = 32'd0;
        endcase
    end

    // effective geometry
    logic [10:0]      w_eff, h_eff;
    logic [COL_W-1:0] wm1;
    logic [ROW_W-1:0] hm1;

    always_comb begin
        w_eff = width_reg;
        if (w_eff == 11'd0) w_eff = 11'd1;
        if (w_eff > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
        h_eff = (height_reg == 11'd0) ? 11'd1 : height_reg;
        wm1   = COL_W'(w_eff - 11'd1);
        hm1   = h_eff - 11'd1;
    end

    // position state
    logic [COL_W-1:0]  in_col_reg, out_col_reg, iss_col_reg;
    logic [ROW_W-1:0]  in_row_reg, out_row_reg;
    logic [SLOT_W-1:0] in_base_reg, out_base_reg;
    logic              lag_reg, win_ok_reg;
    logic [DX_W-1:0]   phase_reg;
    logic [SLOT_W-1:0] iss_slot_reg [WINDOW_SIZE];
    logic              iss_last_reg;

    logic [COL_W-1:0]  in_col_next, out_col_next;
    logic [ROW_W-1:0]  in_row_next, out_row_next;
    logic [SLOT_W-1:0] in_base_next, out_base_next;
    logic              lag_next;

    logic pipe_en, busy, accept, wr_en, ready, issue, refresh, last_now;
    logic [SLOT_W-1:0] wr_bank;
    logic [COL_W-1:0]  c_now, rd_col;
    logic [ROW_W-1:0]  r_now;
    logic [SLOT_W-1:0] slot_now [WINDOW_SIZE];
    logic [DX_W-1:0]   rd_dx;

    logic [1:0] q_cnt_reg;

    assign pipe_en  = (q_cnt_reg != 2'd2);
    assign busy     = (phase_reg != '0);
    assign s_tready = pipe_en && !busy;
    assign accept   = s_tvalid && s_tready;
    assign wr_en    = accept && (s_tuser == FUNC_PIXEL);
    assign wr_bank  = mod_ring(12'(in_base_reg) + 12'(in_row_reg));

    // step: input advance, readiness, output advance
    always_comb begin
        logic [10:0] ic1, oc1;
        logic [11:0] ir1, or1, nr;
        logic [10:0] nc;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_base_next = in_base_reg;
        lag_next     = lag_reg;
        ic1 = 11'(in_col_reg) + 11'd1;
        ir1 = 12'(in_row_reg) + 12'd1;
        if (wr_en) begin
            if (ic1 >= w_eff) begin
                in_col_next = '0;
                if (ir1 >= 12'(h_eff)) begin
                    in_row_next  = '0;
                    in_base_next = mod_ring(12'(in_base_reg) + 12'(h_eff));
                    lag_next     = 1'b1;
                end else begin
                    in_row_next = ir1[ROW_W-1:0];
                end
            end else begin
                in_col_next = ic1[COL_W-1:0];
            end
        end

        nr = 12'(out_row_reg) + 12'(HALF);
        if (nr > 12'(hm1)) nr = 12'(hm1);
        nc = 11'(out_col_reg) + 11'(HALF);
        if (nc > 11'(wm1)) nc = 11'(wm1);
        ready = lag_next || (12'(in_row_next) > nr)
             || ((12'(in_row_next) == nr) && (11'(in_col_next) > nc));
        issue   = accept && ready;
        refresh = (out_col_reg == '0) || !win_ok_reg;

        r_now    = (out_row_reg > hm1) ? hm1 : out_row_reg;
        c_now    = (out_col_reg > wm1) ? wm1 : out_col_reg;
        last_now = (out_row_reg >= hm1) && (out_col_reg >= wm1);

        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        out_base_next = out_base_reg;
        oc1 = 11'(out_col_reg) + 11'd1;
        or1 = 12'(out_row_reg) + 12'd1;
        if (issue) begin
            if (oc1 >= w_eff) begin
                out_col_next = '0;
                if (or1 >= 12'(h_eff)) begin
                    out_row_next  = '0;
                    out_base_next = in_base_next;
                    lag_next      = 1'b0;
                end else begin
                    out_row_next = or1[ROW_W-1:0];
                end
            end else begin
                out_col_next = oc1[COL_W-1:0];
            end
        end
    end

    // window row slots and read column
    always_comb begin
        for (int dy = 0; dy < WINDOW_SIZE; dy++) begin
            slot_now[dy] = row_slot(r_now, DX_W'(dy), hm1, out_base_reg);
        end
        rd_dx  = busy ? (DX_W'(WINDOW_SIZE - 1) - phase_reg) : DX_W'(WINDOW_SIZE - 1);
        rd_col = col_pick(busy ? iss_col_reg : c_now, rd_dx, wm1);
    end

    // position and refresh sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_base_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_base_reg <= '0;
            lag_reg      <= 1'b0;
            win_ok_reg   <= 1'b0;
            phase_reg    <= '0;
        end else begin
            if (accept) begin
                in_col_reg   <= in_col_next;
                in_row_reg   <= in_row_next;
                in_base_reg  <= in_base_next;
                out_col_reg  <= out_col_next;
                out_row_reg  <= out_row_next;
                out_base_reg <= out_base_next;
                lag_reg      <= lag_next;
            end
            if (cfg_we) win_ok_reg <= 1'b0;
            else if (issue && refresh) win_ok_reg <= 1'b1;
            if (issue && refresh) phase_reg <= DX_W'(1);
            else if (busy && pipe_en) begin
                phase_reg <= (phase_reg == DX_W'(WINDOW_SIZE - 1)) ? '0 : phase_reg + DX_W'(1);
            end
        end
    end

    // issue context held over a refresh
    always_ff @(posedge aclk) begin
        if (issue) begin
            iss_col_reg  <= c_now;
            iss_last_reg <= last_now;
            for (int dy = 0; dy < WINDOW_SIZE; dy++) iss_slot_reg[dy] <= slot_now[dy];
        end
    end

    // line banks, one per ring row
    logic [PIX_W-1:0] rd_data [RING_ROWS];

    for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
        logic [PIX_W-1:0] bank_mem [MAX_WIDTH];
        always_ff @(posedge aclk) begin
            if (wr_en && (wr_bank == SLOT_W'(b))) bank_mem[in_col_reg] <= s_tdata;
            if (pipe_en) rd_data[b] <= bank_mem[rd_col];
        end
    end

    // read stage sideband
    logic              rd_v_reg, rd_fin_reg, rd_slide_reg, rd_last_reg;
    logic [DX_W-1:0]   rd_dx_reg;
    logic [SLOT_W-1:0] rd_slot_reg [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] rd_fwd_reg;
    logic [PIX_W-1:0]  rd_wdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg   <= 1'b0;
            rd_fin_reg <= 1'b0;
        end else if (pipe_en) begin
            rd_v_reg   <= issue || busy;
            rd_fin_reg <= (issue && !refresh) || (busy && phase_reg == DX_W'(WINDOW_SIZE - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            rd_slide_reg <= !busy && !refresh;
            rd_dx_reg    <= rd_dx;
            rd_last_reg  <= busy ? iss_last_reg : last_now;
            rd_wdata_reg <= s_tdata;
            for (int dy = 0; dy < WINDOW_SIZE; dy++) begin
                rd_slot_reg[dy] <= busy ? iss_slot_reg[dy] : slot_now[dy];
                // the pixel written this cycle is not yet in the bank
                rd_fwd_reg[dy]  <= wr_en && (slot_now[dy] == wr_bank) && (rd_col == in_col_reg);
            end
        end
    end

    // window columns
    logic [PIX_W-1:0] win_reg [WINDOW_SIZE][WINDOW_SIZE];
    logic [PIX_W-1:0] col_data [WINDOW_SIZE];
    logic             win_fin_reg, win_last_reg;

    always_comb begin
        for (int dy = 0; dy < WINDOW_SIZE; dy++) begin
            col_data[dy] = rd_fwd_reg[dy] ? rd_wdata_reg : rd_data[rd_slot_reg[dy]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && rd_v_reg) begin
            if (rd_slide_reg) begin
                for (int dx = 0; dx < WINDOW_SIZE - 1; dx++) win_reg[dx] <= win_reg[dx + 1];
                win_reg[WINDOW_SIZE - 1] <= col_data;
            end else begin
                win_reg[rd_dx_reg] <= col_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) win_fin_reg <= 1'b0;
        else if (pipe_en) win_fin_reg <= rd_v_reg && rd_fin_reg;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) win_last_reg <= rd_last_reg;
    end

    // pairwise compare stage
    logic             cmp_v_reg, cmp_last_reg;
    logic [PIX_W-1:0] cmp_pix_reg [TAPS];
    logic [TAPS-1:0]  lt_reg [TAPS];
    logic [TAPS-1:0]  le_reg [TAPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) cmp_v_reg <= 1'b0;
        else if (pipe_en) cmp_v_reg <= win_fin_reg;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cmp_last_reg <= win_last_reg;
            for (int i = 0; i < TAPS; i++) begin
                cmp_pix_reg[i] <= win_reg[i % WINDOW_SIZE][i / WINDOW_SIZE];
                for (int j = 0; j < TAPS; j++) begin
                    lt_reg[i][j] <= mask_reg[j] && (win_reg[j % WINDOW_SIZE][j / WINDOW_SIZE]
                                    < win_reg[i % WINDOW_SIZE][i / WINDOW_SIZE]);
                    le_reg[i][j] <= mask_reg[j] && (win_reg[j % WINDOW_SIZE][j / WINDOW_SIZE]
                                    <= win_reg[i % WINDOW_SIZE][i / WINDOW_SIZE]);
                end
            end
        end
    end

    // rank count stage
    logic             cnt_v_reg, cnt_last_reg;
    logic [PIX_W-1:0] cnt_pix_reg [TAPS];
    logic [CNT_W-1:0] cnt_lt_reg [TAPS];
    logic [CNT_W-1:0] cnt_le_reg [TAPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) cnt_v_reg <= 1'b0;
        else if (pipe_en) cnt_v_reg <= cmp_v_reg;
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            cnt_last_reg <= cmp_last_reg;
            for (int i = 0; i < TAPS; i++) begin
                cnt_pix_reg[i] <= cmp_pix_reg[i];
                cnt_lt_reg[i]  <= CNT_W'($countones(lt_reg[i]));
                cnt_le_reg[i]  <= CNT_W'($countones(le_reg[i]));
            end
        end
    end

    // rank pick and error check
    logic [CNT_W-1:0] en_cnt, rank_sel;
    logic             cfg_err;
    logic [PIX_W-1:0] pick;
    logic [PIX_W+1:0] push_data;
    logic             push, pop;

    always_comb begin
        en_cnt   = CNT_W'($countones(mask_reg));
        rank_sel = median_reg ? CNT_W'(en_cnt / MEDIAN_DIV) : CNT_W'(rank_reg);
        cfg_err  = (en_cnt == '0) || (rank_sel >= en_cnt);
        pick     = '0;
        for (int i = 0; i < TAPS; i++) begin
            if (mask_reg[i] && (cnt_lt_reg[i] <= rank_sel) && (rank_sel < cnt_le_reg[i])) begin
                pick = pick | cnt_pix_reg[i];
            end
        end
        push_data = {cnt_last_reg, cfg_err, cfg_err ? PIX_W'(0) : pick};
    end

    assign push = cnt_v_reg && pipe_en;
    assign pop  = m_tvalid && m_tready;

    // output queue
    logic [PIX_W+1:0] q_data_reg [2];

    always_ff @(posedge aclk) begin
        if (!aresetn) q_cnt_reg <= '0;
        else q_cnt_reg <= q_cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push && (q_cnt_reg == 2'd0 || (q_cnt_reg == 2'd1 && pop))) begin
            q_data_reg[0] <= push_data;
        end else if (pop) begin
            q_data_reg[0] <= q_data_reg[1];
        end
        if (push && q_cnt_reg == 2'd1 && !pop) q_data_reg[1] <= push_data;
    end

    assign m_tvalid = (q_cnt_reg != 2'd0);
    assign m_tdata  = q_data_reg[0][PIX_W-1:0];
    assign m_tuser  = q_data_reg[0][PIX_W];
    assign m_tlast  = q_data_reg[0][PIX_W+1];

    // checks
    `MRF_ASSERT_SAME(a_queue_bound, aclk, aresetn, 1'b1, q_cnt_reg != 2'd3, "output queue overflow")
    `MRF_ASSERT_SAME(a_err_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == 8'd0, "error beat carries data")
    `MRF_ASSERT_NEXT(a_refresh_start, aclk, aresetn, issue && refresh, phase_reg == DX_W'(1), "refresh did not start")
    `MRF_ASSERT_NEXT(a_refresh_end, aclk, aresetn, phase_reg == DX_W'(WINDOW_SIZE - 1) && pipe_en, phase_reg == '0, "refresh did not end")

endmodule

// File: sim/tb.sv
// ---------------------------------------------------------------------------
// masked rank filter testbench
// streams frames through the filter and checks each result beat against a
// model of the line buffers, replicated-border window and rank selection
// ---------------------------------------------------------------------------
module tb;
    import mrf_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    class rank_scoreboard;
        int unsigned cfg_width, cfg_height, cfg_mask, cfg_rank, cfg_median;
        logic [7:0]  pix_store [0:RING_ROWS*MAX_WIDTH-1];
        int unsigned in_col, in_row, out_col, out_row, in_base, out_base;
        bit          lag;
        logic [9:0]  pending [$];
        int unsigned n_pixel, n_drain, n_result, n_error_beat, n_fail;

        function new();
            cfg_width  = 1024;
            cfg_height = 1024;
            cfg_mask   = 32'h1FF_FFFF;
            cfg_rank   = 12;
            cfg_median = 0;
            foreach (pix_store[i]) pix_store[i] = 8'd0;
            in_col = 0; in_row = 0; out_col = 0; out_row = 0;
            in_base = 0; out_base = 0; lag = 0;
        endfunction

        function void set_reg(logic [2:0] idx, int unsigned val);
            case (idx)
                REG_WIDTH:  cfg_width  = val & 32'h7FF;
                REG_HEIGHT: cfg_height = val & 32'h7FF;
                REG_MASK:   cfg_mask   = val & 32'h1FF_FFFF;
                REG_RANK:   cfg_rank   = val & 32'h1F;
                REG_MEDIAN: cfg_median = val & 32'h1;
                default: ;
            endcase
        endfunction

        function int unsigned slot_addr(int unsigned base, int unsigned r, int unsigned c);
            return ((base + r) % RING_ROWS) * MAX_WIDTH + (c % MAX_WIDTH);
        endfunction

        // every output position of the current frame has been produced
        function bit frame_idle();
            return in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0 && !lag;
        endfunction

        // advance the model by one accepted input beat
        function void note_input(logic func, logic [7:0] pix);
            int unsigned w, h, nr, nc, n, k;
            int          r, c, rr, cc, i, j;
            logic [7:0]  win [0:TAPS-1];
            logic [7:0]  key, val;
            bit          ready, err, last;
            w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
            h = (cfg_height == 0) ? 1 : cfg_height;
            // store pixel and advance input position
            if (func == FUNC_PIXEL) begin
                n_pixel++;
                pix_store[slot_addr(in_base, in_row, in_col)] = pix;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                    if (in_row >= h) begin
                        in_row = 0;
                        in_base = (in_base + h) % RING_ROWS;
                        lag = 1;
                    end
                end
            end else begin
                n_drain++;
            end
            // output readiness
            if (lag) begin
                ready = 1;
            end else begin
                nr = out_row + HALF;
                nc = out_col + HALF;
                if (nr > h - 1) nr = h - 1;
                if (nc > w - 1) nc = w - 1;
                ready = (in_row > nr) || (in_row == nr && in_col > nc);
            end
            if (!ready) return;
            // gather enabled window taps with replicated border
            n = 0;
            r = (out_row < h) ? out_row : h - 1;
            c = (out_col < w) ? out_col : w - 1;
            for (int dy = 0; dy < WINDOW_SIZE; dy++) begin
                for (int dx = 0; dx < WINDOW_SIZE; dx++) begin
                    if (cfg_mask[dy*WINDOW_SIZE+dx]) begin
                        rr = r + dy - HALF;
                        cc = c + dx - HALF;
                        if (rr < 0) rr = 0;
                        if (rr > int'(h) - 1) rr = h - 1;
                        if (cc < 0) cc = 0;
                        if (cc > int'(w) - 1) cc = w - 1;
                        win[n] = pix_store[slot_addr(out_base, rr, cc)];
                        n++;
                    end
                end
            end
            k = cfg_median ? n / MEDIAN_DIV : cfg_rank;
            err = (n == 0) || (k >= n);
            val = 8'd0;
            if (!err) begin
                // insertion sort of the gathered taps
                for (i = 1; i < int'(n); i++) begin
                    key = win[i];
                    j = i;
                    while (j > 0 && win[j-1] > key) begin
                        win[j] = win[j-1];
                        j--;
                    end
                    win[j] = key;
                end
                val = win[k];
            end
            last = (out_row >= h - 1) && (out_col >= w - 1);
            pending.insert(pending.size(), {last, err, val});
            // advance output position
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
                if (out_row >= h) begin
                    out_row = 0;
                    out_base = in_base;
                    lag = 0;
                end
            end
        endfunction

        // compare one result beat with the oldest expected result
        function void check_result(logic [7:0] pix, logic err, logic last);
            logic [9:0] exp_beat;
            n_result++;
            if (err) n_error_beat++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result beat pixel=%0d err=%0b last=%0b",
                         $time, pix, err, last);
                n_fail++;
                return;
            end
            exp_beat = pending.pop_front();
            if (pix !== exp_beat[7:0]) begin
                $display("%0t: pixel_out expected %0d actual %0d", $time, exp_beat[7:0], pix);
                n_fail++;
            end
            if (err !== exp_beat[8]) begin
                $display("%0t: config_error expected %0b actual %0b", $time, exp_beat[8], err);
                n_fail++;
            end
            if (last !== exp_beat[9]) begin
                $display("%0t: frame_last expected %0b actual %0b", $time, exp_beat[9], last);
                n_fail++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] pixel_in
    logic        s_tuser;   // [0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] pixel_out
    logic        m_tuser;   // [0] config_error
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rank_scoreboard sb;
    int unsigned cycle_count = 0;
    int unsigned hold_cycles;
    int unsigned stall_left;
    bit          quiet;
    int unsigned n_phase;

    masked_rank_filter_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // timeout watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL masked_rank_filter_unit");
            $finish;
        end
    end

    // gap length: mostly short, a few long
    function automatic int unsigned pick_gap();
        if (quiet) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls plus one long hold-off
    initial begin
        m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) stall_left = pick_gap();
            end
        end
    end

    // register write: setup phase, access phase, then an idle phase
    task automatic reg_write(logic [2:0] idx, int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(int unsigned w, int unsigned h, int unsigned mask,
                             int unsigned rank, int unsigned med);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_MASK, mask);
        reg_write(REG_RANK, rank);
        reg_write(REG_MEDIAN, med);
        n_phase++;
    endtask

    // offer one input beat and wait for it to be taken
    task automatic send_beat(logic func, logic [7:0] pix);
        int unsigned gap;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(func, pix);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_results();
        while (sb.pending.size() != 0) @(posedge aclk);
    endtask

    // drain the frame, then let the pipeline settle before the next write
    task automatic finish_phase();
        while (!sb.frame_idle()) send_beat(FUNC_DRAIN, 8'($urandom));
        s_tvalid <= 1'b0;
        wait_results();
        repeat (20) @(posedge aclk);
    endtask

    // whole frames of random pixels with drain beats mixed in
    task automatic send_frames(int unsigned frames, int unsigned drain_pct);
        int unsigned w, h;
        w = (sb.cfg_width == 0) ? 1 : ((sb.cfg_width > MAX_WIDTH) ? MAX_WIDTH : sb.cfg_width);
        h = (sb.cfg_height == 0) ? 1 : sb.cfg_height;
        repeat (frames * w * h) begin
            while ($urandom_range(0, 99) < drain_pct) send_beat(FUNC_DRAIN, 8'($urandom));
            send_beat(FUNC_PIXEL, 8'($urandom));
        end
    endtask

    function automatic int unsigned pick_mask();
        case ($urandom_range(0, 5))
            0: return 32'h1FF_FFFF;
            1: return 32'h0;
            2: return 32'h1 << $urandom_range(0, 24);
            3: return 32'h0_0739C0;
            default: return $urandom & 32'h1FF_FFFF;
        endcase
    endfunction

    initial begin
        sb = new();
        hold_cycles = 0;
        quiet = 0;
        n_phase = 0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tuser  = FUNC_PIXEL;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // directed: extremes of pixels, full mask, lowest rank
        configure(4, 3, 32'h1FF_FFFF, 0, 0);
        for (int i = 0; i < 12; i++) send_beat(FUNC_PIXEL, (i % 2) ? 8'd255 : 8'd0);
        finish_phase();
        // highest rank with full mask, then median mode
        configure(3, 2, 32'h1FF_FFFF, 24, 0);
        for (int i = 0; i < 6; i++) send_beat(FUNC_PIXEL, 8'(i * 50));
        finish_phase();
        configure(3, 1, 32'h00_0421, 24, 1);
        for (int i = 0; i < 3; i++) send_beat(FUNC_PIXEL, 8'(255 - i));
        finish_phase();
        // empty mask and out-of-range rank give error beats; single-pixel frame
        configure(1, 1, 32'h0, 0, 0);
        send_beat(FUNC_DRAIN, 8'd0);
        send_beat(FUNC_PIXEL, 8'd77);
        finish_phase();
        configure(2, 1, 32'h100_0001, 2, 0);
        send_beat(FUNC_PIXEL, 8'd1);
        send_beat(FUNC_PIXEL, 8'd2);
        finish_phase();

        // a long row and a tall column, each once
        configure(512, 1, pick_mask(), $urandom_range(0, 24), $urandom_range(0, 1));
        quiet = 1;
        send_frames(1, 0);
        quiet = 0;
        finish_phase();
        configure(1, 128, pick_mask(), $urandom_range(0, 24), $urandom_range(0, 1));
        send_frames(1, 2);
        finish_phase();

        // long output hold-off while pixels keep coming, so the input backs up
        configure(16, 8, 32'h1FF_FFFF, 12, 1);
        hold_cycles = 300;
        send_frames(2, 0);
        finish_phase();

        // random phases of small frames
        while (sb.n_pixel < 1000) begin
            configure($urandom_range(1, 12), $urandom_range(1, 8), pick_mask(),
                      $urandom_range(0, 24), ($urandom_range(0, 2) == 0));
            quiet = ($urandom_range(0, 4) == 0);
            send_frames($urandom_range(1, 3), $urandom_range(0, 15));
            if ($urandom_range(0, 3) == 0) begin
                // pause until every pending result is out
                s_tvalid <= 1'b0;
                @(posedge aclk);
                wait_results();
            end
            quiet = 0;
            finish_phase();
        end

        wait_results();
        repeat (20) @(posedge aclk);
        $display("run covered %0d phases, %0d pixels, %0d drain beats", n_phase,
                 sb.n_pixel, sb.n_drain);
        $display("checked %0d result beats, %0d of them flagged as config errors",
                 sb.n_result, sb.n_error_beat);
        if (sb.n_fail == 0 && sb.pending.size() == 0) begin
            $display("PASS masked_rank_filter_unit");
        end else begin
            $display("FAIL masked_rank_filter_unit");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/mrf_pkg.sv
rtl/masked_rank_filter_unit.sv
sim/tb.sv
